### src/ordered_unique_set_table_defines.svh
// Assertion macros shared by the ordered unique set table RTL.
// The macros expect clk_i and rst_ni to be visible where they are used.
`ifndef ORDERED_UNIQUE_SET_TABLE_DEFINES_SVH
`define ORDERED_UNIQUE_SET_TABLE_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define OUST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define OUST_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

### src/oust_pkg.sv
// Package for the ordered unique set table: request and result types, codes, constants.
// Depends on nothing; used by the engine and the top level.
`timescale 1ns / 1ps

package oust_pkg;

  localparam int unsigned KIND_W       = 2;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned INDEX_W      = 7;
  localparam int unsigned COUNT_W      = 7;
  localparam int unsigned CAPACITY_DEF = 64;

  // Data returned by a read-at request whose index is not below the count.
  localparam logic signed [DATA_W-1:0] READ_MISS = -32'sd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT   = 2'd0,
    KIND_ERASE    = 2'd1,
    KIND_CONTAINS = 2'd2,
    KIND_READ     = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                     kind;
    logic signed [DATA_W-1:0]  value;
    logic        [INDEX_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic                      present;
    logic                      refused_full;
    logic                      in_range;
    logic signed [DATA_W-1:0]  data;
    logic        [COUNT_W-1:0] count;
  } res_t;

endpackage

### src/oust_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module oust_ram #(
  parameter  int unsigned Width = 32,
  parameter  int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/oust_engine.sv
// Sequencer of the ordered unique set table: scans, shifts and reads the entry RAM.
// Depends on oust_pkg, oust_ram and ordered_unique_set_table_defines.svh.
`timescale 1ns / 1ps
`include "ordered_unique_set_table_defines.svh"

module oust_engine #(
  parameter int unsigned Capacity = oust_pkg::CAPACITY_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  oust_pkg::req_t  req_i,
  output logic            ready_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output oust_pkg::res_t  res_o
);

  import oust_pkg::*;

  localparam int unsigned AW   = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CW   = $clog2(Capacity + 1);
  localparam int unsigned CMPW = (CW > INDEX_W) ? CW : INDEX_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_READ,
    ST_RESP
  } state_e;

  state_e          state_q, state_d;
  req_t            req_q, req_d;
  res_t            res_q, res_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   ptr_q, ptr_d;
  logic [CW-1:0]   cptr_q, cptr_d;
  logic            vld_q, vld_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  oust_ram #(
    .Width (DATA_W),
    .Depth (Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    logic issue;
    logic hit;
    issue = ptr_q < count_q;
    hit   = vld_q && (ram_rdata == $unsigned(req_q.value));

    state_d   = state_q;
    req_d     = req_q;
    res_d     = res_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    cptr_d    = cptr_q;
    vld_d     = vld_q;
    ram_we    = 1'b0;
    ram_waddr = AW'(cptr_q);
    ram_wdata = ram_rdata;
    ram_raddr = AW'(ptr_q);

    case (state_q)
      ST_IDLE: begin
        ram_raddr = AW'(req_i.index);
        if (start_i) begin
          req_d = req_i;
          res_d = '0;
          ptr_d = '0;
          vld_d = 1'b0;
          if (req_i.kind == KIND_READ) begin
            if (CMPW'(req_i.index) < CMPW'(count_q)) begin
              state_d = ST_READ;
            end else begin
              res_d.data = READ_MISS;
              state_d    = ST_RESP;
            end
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (hit) begin
          // First match sits at cptr_q.
          res_d.present = 1'b1;
          if (req_q.kind == KIND_ERASE) begin
            ptr_d   = cptr_q + CW'(1);
            vld_d   = 1'b0;
            state_d = ST_SHIFT;
          end else begin
            state_d = ST_RESP;
          end
        end else if (!vld_q && !issue) begin
          // Every entry compared without a match.
          if (req_q.kind == KIND_INSERT) begin
            if (count_q == CW'(Capacity)) begin
              res_d.refused_full = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = AW'(count_q);
              ram_wdata = req_q.value;
              count_d   = count_q + CW'(1);
            end
          end
          state_d = ST_RESP;
        end else begin
          vld_d  = issue;
          cptr_d = ptr_q;
          if (issue) begin
            ptr_d = ptr_q + CW'(1);
          end
        end
      end

      ST_SHIFT: begin
        // Entry read last cycle moves down one place.
        if (vld_q) begin
          ram_we = 1'b1;
        end
        if (!vld_q && !issue) begin
          count_d = count_q - CW'(1);
          state_d = ST_RESP;
        end else begin
          vld_d = issue;
          if (issue) begin
            cptr_d = ptr_q - CW'(1);
            ptr_d  = ptr_q + CW'(1);
          end
        end
      end

      ST_READ: begin
        res_d.in_range = 1'b1;
        res_d.data     = $signed(ram_rdata);
        state_d        = ST_RESP;
      end

      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (state_d == ST_RESP) begin
      res_d.count = COUNT_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    res_q  <= res_d;
    ptr_q  <= ptr_d;
    cptr_q <= cptr_d;
  end

  assign ready_o     = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_RESP);
  assign res_o       = res_q;

  `OUST_ASSERT(a_count_bound, count_q <= CW'(Capacity), "entry count above capacity")
  `OUST_NEVER(a_present_refused, res_valid_o && res_q.present && res_q.refused_full,
    "refused insert reported a present value")
  `OUST_ASSERT(a_refused_full, (res_valid_o && res_q.refused_full) |-> (count_q == CW'(Capacity)),
    "insert refused while table has room")
  `OUST_ASSERT(a_shift_write, (state_q == ST_SHIFT && ram_we) |-> (cptr_q + CW'(1) < count_q),
    "shift writes outside the occupied entries")

endmodule

### src/ordered_unique_set_table.sv
// Top level of the ordered unique set table: input capture and output register.
// Depends on oust_pkg, oust_engine and oust_ram.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid_i / in_ready_o) carries one request per transaction:
// kind_i selects insert, erase, contains or read-at, value_i is the value to
// insert, erase or test, index_i the position for a read-at. The output channel
// (out_valid_o / out_ready_i) returns exactly one result transaction per request,
// in request order, with the entry count after the request.
// Entries live in a single RAM with a registered read port, and a small sequencer
// walks it one entry per cycle. A read-at fetches its entry in a read state, or
// goes straight to the result when the index misses. Contains, insert and erase
// scan the entries in order until a match or the end. A present erase finds its
// entry and then moves each later entry down one place, one per cycle. The one RAM
// read port serves both the scan and the shift.
// in_ready_o is high only while the sequencer is idle, one request at a time.
// A finished result moves into the output register, so a new request is taken
// while the receiver stalls; a second result then waits inside the sequencer.
// Reset empties the table (count zero); the RAM contents need no clearing.

module ordered_unique_set_table #(
  parameter int unsigned Capacity = oust_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic        [oust_pkg::KIND_W-1:0]  kind_i,
  input  logic signed [oust_pkg::DATA_W-1:0]  value_i,
  input  logic        [oust_pkg::INDEX_W-1:0] index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                present_o,
  output logic                                refused_full_o,
  output logic                                in_range_o,
  output logic signed [oust_pkg::DATA_W-1:0]  data_o,
  output logic        [oust_pkg::COUNT_W-1:0] count_o
);

  import oust_pkg::*;

  req_t req;
  res_t eng_res;
  logic eng_ready;
  logic eng_res_valid;
  logic load;

  logic out_valid_q, out_valid_d;
  res_t out_q;

  // Pack the request fields; the kind code is taken as it stands.
  always_comb begin
    req.kind  = kind_e'(kind_i);
    req.value = value_i;
    req.index = index_i;
  end

  oust_engine #(
    .Capacity (Capacity)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && eng_ready),
    .req_i       (req),
    .ready_o     (eng_ready),
    .res_valid_o (eng_res_valid),
    .res_ready_i (load),
    .res_o       (eng_res)
  );

  // The output register takes a new result when it is empty or being drained.
  assign load = eng_res_valid && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= eng_res;
    end
  end

  assign in_ready_o     = eng_ready;
  assign out_valid_o    = out_valid_q;
  assign present_o      = out_q.present;
  assign refused_full_o = out_q.refused_full;
  assign in_range_o     = out_q.in_range;
  assign data_o         = out_q.data;
  assign count_o        = out_q.count;

endmodule

### verif/tb_top.sv
// Self-checking testbench for ordered_unique_set_table: directed and random request streams.
// Depends on oust_pkg and the ordered_unique_set_table RTL; reads no files.
`timescale 1ns / 1ps

module tb_top;
  import oust_pkg::*;

  localparam int unsigned CAP = CAPACITY_DEF;
  // Longest request is an erase that hits in a full table: scan plus shift pass.
  localparam int unsigned WORST_LATENCY = 2 * CAP + 4;
  // Cycles without any transaction on either channel before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 40 * WORST_LATENCY;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic        [KIND_W-1:0]  req_kind = KIND_INSERT;
  logic signed [DATA_W-1:0]  req_value = '0;
  logic        [INDEX_W-1:0] req_index = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      present;
  logic                      refused_full;
  logic                      in_range;
  logic signed [DATA_W-1:0]  data;
  logic        [COUNT_W-1:0] count;

  // Shadow copy of the table, kept in insertion order, and the results still owed.
  logic signed [DATA_W-1:0] set_entries[$];
  res_t                     pending_results[$];

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned stall_cycles = 0;
  int unsigned mismatches = 0;

  // Coverage tallies for the closing summary.
  int unsigned n_requests = 0;
  int unsigned n_refused = 0;
  int unsigned n_dup_inserts = 0;
  int unsigned n_erase_hits = 0;
  int unsigned n_read_hits = 0;
  int unsigned n_read_misses = 0;
  int unsigned peak_count = 0;

  ordered_unique_set_table #(
    .Capacity(CAP)
  ) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .kind_i        (req_kind),
    .value_i       (req_value),
    .index_i       (req_index),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .present_o     (present),
    .refused_full_o(refused_full),
    .in_range_o    (in_range),
    .data_o        (data),
    .count_o       (count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Position of the first matching entry in the shadow table, or -1 when absent.
  function automatic int find_entry(logic signed [DATA_W-1:0] value);
    foreach (set_entries[i]) begin
      if (set_entries[i] == value) return i;
    end
    return -1;
  endfunction

  // Applies one request to the shadow table and returns the result the block owes for it.
  function automatic res_t apply_set_request(kind_e kind, logic signed [DATA_W-1:0] value,
                                             logic [INDEX_W-1:0] index);
    res_t r;
    int   pos;
    r   = '0;
    pos = find_entry(value);
    case (kind)
      KIND_INSERT: begin
        if (pos >= 0) begin
          r.present = 1'b1;
          n_dup_inserts++;
        end else if (set_entries.size() >= CAP) begin
          r.refused_full = 1'b1;
          n_refused++;
        end else begin
          set_entries.push_back(value);
        end
      end
      KIND_ERASE: begin
        if (pos >= 0) begin
          r.present = 1'b1;
          set_entries.delete(pos);
          n_erase_hits++;
        end
      end
      KIND_CONTAINS: begin
        r.present = (pos >= 0);
      end
      default: begin
        if (index < set_entries.size()) begin
          r.in_range = 1'b1;
          r.data     = set_entries[index];
          n_read_hits++;
        end else begin
          r.data = READ_MISS;
          n_read_misses++;
        end
      end
    endcase
    r.count = COUNT_W'(set_entries.size());
    if (set_entries.size() > peak_count) peak_count = set_entries.size();
    return r;
  endfunction

  // Presents one request, holding it stable until the block takes it, then records what
  // the block must answer. Valid is only dropped for sender idle cycles.
  task automatic send_request(input kind_e kind, input logic signed [DATA_W-1:0] value,
                              input logic [INDEX_W-1:0] index);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_kind  <= kind;
    req_value <= value;
    req_index <= index;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_set_request(kind, value, index));
    n_requests++;
  endtask

  // Values are drawn so that hits are common: live entries, a small cluster around zero,
  // the signed extremes, and fully random words that exercise every bit.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 45 && set_entries.size() > 0) begin
      return set_entries[$urandom_range(set_entries.size() - 1)];
    end
    if (sel < 70) return $signed(DATA_W'($urandom_range(15))) - 8;
    if (sel < 76) begin
      case ($urandom_range(3))
        0: return {1'b1, {(DATA_W-1){1'b0}}};
        1: return {1'b0, {(DATA_W-1){1'b1}}};
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  // Read indexes mostly land from zero up to the live count, sometimes anywhere in range.
  function automatic logic [INDEX_W-1:0] pick_index();
    if ($urandom_range(99) < 70) return INDEX_W'($urandom_range(set_entries.size()));
    return INDEX_W'($urandom_range(2**INDEX_W - 1));
  endfunction

  // Empty table: reads miss at both ends of the index range, lookups and erases find nothing.
  task automatic test_empty_table();
    send_request(KIND_READ, $urandom, '0);
    send_request(KIND_READ, $urandom, '1);
    send_request(KIND_CONTAINS, '0, INDEX_W'($urandom));
    send_request(KIND_ERASE, '1, INDEX_W'($urandom));
  endtask

  // Signed extremes, duplicate insert, ordered reads, and erases at the front, middle and end
  // that must close the gap while keeping the order.
  task automatic test_value_extremes();
    logic signed [DATA_W-1:0] min_val;
    logic signed [DATA_W-1:0] max_val;
    min_val = {1'b1, {(DATA_W-1){1'b0}}};
    max_val = {1'b0, {(DATA_W-1){1'b1}}};
    send_request(KIND_INSERT, min_val, '1);
    send_request(KIND_INSERT, max_val, '0);
    send_request(KIND_INSERT, '0, '0);
    send_request(KIND_INSERT, '1, '1);
    send_request(KIND_INSERT, max_val, '0);
    send_request(KIND_CONTAINS, min_val, '0);
    send_request(KIND_CONTAINS, 32'sd12345, '0);
    for (int i = 0; i < 5; i++) send_request(KIND_READ, $urandom, INDEX_W'(i));
    send_request(KIND_READ, '0, '1);
    send_request(KIND_ERASE, '0, '0);
    send_request(KIND_READ, '0, INDEX_W'(2));
    send_request(KIND_ERASE, min_val, '0);
    send_request(KIND_ERASE, 32'sd5, '0);
    send_request(KIND_READ, '0, '0);
    send_request(KIND_ERASE, '1, '0);
    send_request(KIND_ERASE, max_val, '0);
    send_request(KIND_READ, '0, '0);
  endtask

  // Fills the table to capacity with random values, pushes against the full boundary with
  // refused and duplicate inserts, churns one slot, then drains it by erasing at random spots.
  task automatic test_fill_and_drain();
    int unsigned pos;
    while (set_entries.size() < CAP) begin
      if ($urandom_range(9) == 0) send_request(KIND_INSERT, pick_value(), INDEX_W'($urandom));
      else send_request(KIND_INSERT, $urandom, INDEX_W'($urandom));
    end
    repeat (3) send_request(KIND_INSERT, $urandom, INDEX_W'($urandom));
    send_request(KIND_INSERT, set_entries[$urandom_range(CAP - 1)], INDEX_W'($urandom));
    send_request(KIND_READ, $urandom, INDEX_W'(CAP - 1));
    send_request(KIND_READ, $urandom, INDEX_W'(CAP));
    send_request(KIND_CONTAINS, set_entries[CAP - 1], INDEX_W'($urandom));
    repeat (4) begin
      send_request(KIND_ERASE, set_entries[$urandom_range(CAP - 1)], INDEX_W'($urandom));
      send_request(KIND_INSERT, $urandom, INDEX_W'($urandom));
      send_request(KIND_INSERT, $urandom, INDEX_W'($urandom));
    end
    while (set_entries.size() > 0) begin
      pos = $urandom_range(set_entries.size() - 1);
      case ($urandom_range(7))
        0: send_request(KIND_ERASE, $urandom, INDEX_W'($urandom));
        1: send_request(KIND_READ, $urandom, pick_index());
        default: send_request(KIND_ERASE, set_entries[pos], INDEX_W'($urandom));
      endcase
    end
  endtask

  // Mixed traffic weighted toward inserts so the count wanders over its whole range.
  task automatic test_random_mix(input int unsigned n_items);
    int unsigned sel;
    repeat (n_items) begin
      sel = $urandom_range(99);
      if (sel < 40) send_request(KIND_INSERT, pick_value(), INDEX_W'($urandom));
      else if (sel < 62) send_request(KIND_ERASE, pick_value(), INDEX_W'($urandom));
      else if (sel < 80) send_request(KIND_CONTAINS, pick_value(), INDEX_W'($urandom));
      else send_request(KIND_READ, $urandom, pick_index());
    end
  endtask

  task automatic compare_field(input string name, input logic signed [DATA_W:0] want,
                               input logic signed [DATA_W:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result side: checks each transaction against the oldest expectation, then decides
  // whether the receiver stalls in the next cycle.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, present %0b refused_full %0b in_range %0b",
                 $time, present, refused_full, in_range);
        $display("%0t: unexpected result, data %0d count %0d", $time, data, count);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("present", (DATA_W+1)'(want.present), (DATA_W+1)'(present));
        compare_field("refused_full", (DATA_W+1)'(want.refused_full),
                      (DATA_W+1)'(refused_full));
        compare_field("in_range", (DATA_W+1)'(want.in_range), (DATA_W+1)'(in_range));
        compare_field("data", (DATA_W+1)'(want.data), (DATA_W+1)'(data));
        compare_field("count", (DATA_W+1)'(want.count), (DATA_W+1)'(count));
      end
    end
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Counts cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("%0t: no transaction for %0d cycles, %0d results outstanding",
             $time, stall_cycles, pending_results.size());
    $display("ordered_unique_set_table test failed");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles often and receiver stalls more: gaps land on every phase of a scan.
    sender_idle_pct   = 29;
    receiver_idle_pct = 60;
    test_empty_table();
    test_value_extremes();
    test_fill_and_drain();
    test_random_mix(90);

    // Roles swapped: results mostly drain at once while requests trickle in.
    sender_idle_pct   = 60;
    receiver_idle_pct = 29;
    test_fill_and_drain();
    test_random_mix(90);

    // Back to back on both sides.
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    test_fill_and_drain();
    test_random_mix(90);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (WORST_LATENCY + 10) @(posedge clk);

    $display("Sent %0d requests; peak count %0d of %0d, %0d refused and %0d duplicate inserts.",
             n_requests, peak_count, CAP, n_refused, n_dup_inserts);
    $display("Erase hits %0d, read-at hits %0d and misses %0d, under three idle patterns.",
             n_erase_hits, n_read_hits, n_read_misses);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ordered_unique_set_table test passed");
    end else begin
      $display("ordered_unique_set_table test failed");
    end
    $finish;
  end

endmodule
